[hdl/ccrc_pkg.sv]
// shared types, constants and register indexes for the configurable crc engine
package ccrc_pkg;

  localparam int MAX_WORD_BITS = 32;
  localparam int DATA_W        = 32;
  localparam int CRC_W         = 32;
  localparam int OUT_W         = 31;
  localparam int ORDER_W       = 5;
  localparam int WIDTH_W       = 6;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int TDATA_IN_W    = 32;
  localparam int TDATA_OUT_W   = 32;

  // the bit loop is cut into slices of this many dependent steps
  localparam int STEP_BITS = 8;
  localparam int NUM_STEPS = MAX_WORD_BITS / STEP_BITS;
  localparam int CNT_W     = $clog2(STEP_BITS + 1);

  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(8);
  localparam logic [CRC_W-1:0]   POLY_RST  = CRC_W'(32'h0000_008C);
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(8);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CRC_ORDER  = 2'd0,
    REG_POLYNOMIAL = 2'd1,
    REG_WORD_WIDTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ORDER_W-1:0] crc_order;
    logic [CRC_W-1:0]   polynomial;
    logic [WIDTH_W-1:0] word_width;
  } cfg_t;

endpackage

[hdl/ccrc_byte_step.sv]
// up to eight lsb-first crc shift steps on one slice of the data word
module ccrc_byte_step (
  input  logic [ccrc_pkg::CRC_W-1:0]     crc_in,
  input  logic [ccrc_pkg::STEP_BITS-1:0] data,
  input  logic [ccrc_pkg::CNT_W-1:0]     bit_cnt,
  input  logic [ccrc_pkg::CRC_W-1:0]     polynomial,
  output logic [ccrc_pkg::CRC_W-1:0]     crc_out
);

  always_comb begin
    logic [ccrc_pkg::CRC_W-1:0] c;
    logic                       fb;
    c  = crc_in;
    fb = 1'b0;
    for (int i = 0; i < ccrc_pkg::STEP_BITS; i++) begin
      if (ccrc_pkg::CNT_W'(i) < bit_cnt) begin
        fb = c[0] ^ data[i];
        c  = {1'b0, c[ccrc_pkg::CRC_W-1:1]} ^ (polynomial & {ccrc_pkg::CRC_W{fb}});
      end
    end
    crc_out = c;
  end

endmodule

[hdl/ccrc_update.sv]
// preset, chained slice steps and output masking for one data word
module ccrc_update (
  input  ccrc_pkg::cfg_t                cfg,
  input  logic                          at_start,
  input  logic [ccrc_pkg::CRC_W-1:0]    crc_in,
  input  logic [ccrc_pkg::DATA_W-1:0]   data_word,
  output logic [ccrc_pkg::CRC_W-1:0]    crc_out,
  output logic [ccrc_pkg::OUT_W-1:0]    crc_value
);

  logic [ccrc_pkg::CRC_W-1:0]   order_mask;
  logic [ccrc_pkg::WIDTH_W-1:0] n_sat;
  logic [ccrc_pkg::CNT_W-1:0]   cnt   [ccrc_pkg::NUM_STEPS];
  logic [ccrc_pkg::CRC_W-1:0]   chain [ccrc_pkg::NUM_STEPS+1];

  assign order_mask = (ccrc_pkg::CRC_W'(1) << cfg.crc_order) - ccrc_pkg::CRC_W'(1);
  assign n_sat = (cfg.word_width > ccrc_pkg::WIDTH_W'(ccrc_pkg::MAX_WORD_BITS)) ?
                 ccrc_pkg::WIDTH_W'(ccrc_pkg::MAX_WORD_BITS) : cfg.word_width;

  // bits each slice consumes
  always_comb begin
    for (int k = 0; k < ccrc_pkg::NUM_STEPS; k++) begin
      if (n_sat >= ccrc_pkg::WIDTH_W'((k + 1) * ccrc_pkg::STEP_BITS)) begin
        cnt[k] = ccrc_pkg::CNT_W'(ccrc_pkg::STEP_BITS);
      end else if (n_sat > ccrc_pkg::WIDTH_W'(k * ccrc_pkg::STEP_BITS)) begin
        cnt[k] = ccrc_pkg::CNT_W'(n_sat - ccrc_pkg::WIDTH_W'(k * ccrc_pkg::STEP_BITS));
      end else begin
        cnt[k] = '0;
      end
    end
  end

  assign chain[0] = at_start ? order_mask : crc_in;

  for (genvar k = 0; k < ccrc_pkg::NUM_STEPS; k++) begin : g_step
    ccrc_byte_step u_step (
      .crc_in     (chain[k]),
      .data       (data_word[k*ccrc_pkg::STEP_BITS +: ccrc_pkg::STEP_BITS]),
      .bit_cnt    (cnt[k]),
      .polynomial (cfg.polynomial),
      .crc_out    (chain[k+1])
    );
  end

  assign crc_out   = chain[ccrc_pkg::NUM_STEPS];
  assign crc_value = ccrc_pkg::OUT_W'(~chain[ccrc_pkg::NUM_STEPS] & order_mask);

endmodule

[hdl/configurable_crc_engine_core.sv]
// top level of the configurable reflected crc engine
//
// usage: data words arrive on the in_ stream, one beat per word; in_tlast
// marks the final word of a block. the low word_width bits of each word are
// shifted into the crc lsb first. on the last beat of a block one result beat
// leaves on the out_ stream carrying the inverted crc masked to crc_order
// bits, and the next beat starts a new block from an all-ones preset.
// flow: an advancing beat loads the crc register and, for a last beat, the
// result register. throughput: one beat per cycle unless a held result stalls
// a last beat; the whole word goes through a chain of four 8-bit step slices
// between the input register and the crc register. the user must write
// configuration (crc_order, polynomial, word_width) through the cfg_ port
// while the block is idle, one register per cycle; the block does not
// enforce this. reset: synchronous, active low; clears both beat registers,
// restores the register defaults and arms the preset for the first block.
// stall: a held result stops only last beats; other beats keep flowing, and
// the input register takes a new beat whenever its content moves on.
module configurable_crc_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccrc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ccrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ccrc_pkg::TDATA_IN_W-1:0]     in_tdata,   // [31:0] data_word
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ccrc_pkg::TDATA_OUT_W-1:0]    out_tdata   // [30:0] crc_value, [31] zero
);

  ccrc_pkg::cfg_t                  cfg_r;
  logic                            in_valid_r;
  logic [ccrc_pkg::DATA_W-1:0]     in_data_r;
  logic                            in_last_r;
  logic                            at_start_r;
  logic [ccrc_pkg::CRC_W-1:0]      crc_r;
  logic                            out_valid_r;
  logic [ccrc_pkg::OUT_W-1:0]      out_crc_r;
  logic [ccrc_pkg::CRC_W-1:0]      crc_nxt;
  logic [ccrc_pkg::OUT_W-1:0]      crc_value;
  logic                            advance;
  logic [ccrc_pkg::CRC_W-1:0]      out_mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_order  <= ccrc_pkg::ORDER_RST;
      cfg_r.polynomial <= ccrc_pkg::POLY_RST;
      cfg_r.word_width <= ccrc_pkg::WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ccrc_pkg::REG_CRC_ORDER:  cfg_r.crc_order  <= cfg_wdata[ccrc_pkg::ORDER_W-1:0];
        ccrc_pkg::REG_POLYNOMIAL: cfg_r.polynomial <= cfg_wdata[ccrc_pkg::CRC_W-1:0];
        ccrc_pkg::REG_WORD_WIDTH: cfg_r.word_width <= cfg_wdata[ccrc_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // a non-last beat never needs the output slot
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  ccrc_update u_update (
    .cfg       (cfg_r),
    .at_start  (at_start_r),
    .crc_in    (crc_r),
    .data_word (in_data_r),
    .crc_out   (crc_nxt),
    .crc_value (crc_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
    end else if (advance) begin
      at_start_r <= in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_crc_r <= crc_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_crc_r};

  assign out_mask = (ccrc_pkg::CRC_W'(1) << cfg_r.crc_order) - ccrc_pkg::CRC_W'(1);

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && in_last_r))
    else $error("result appeared without a last beat");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> at_start_r)
    else $error("preset not armed after last beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_data_r) && $stable(in_last_r)))
    else $error("held input beat was lost");

  a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((ccrc_pkg::CRC_W'(out_crc_r) & ~out_mask) == '0))
    else $error("result has bits above crc order");

endmodule
